// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the top-level RTL. They expect clk and rst_n
// to be visible at the point of use.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/twgc_pkg.sv
// ---------------------------------------------------------------------------
// twgc_pkg
// Shared types and constants of the TCP window growth controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package twgc_pkg;

    localparam int unsigned ADDR_W = 3;

    localparam logic [15:0] MSS_RESET   = 16'd1460;
    localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_SEGMENT_SIZE     = 1'b0,
        REG_SLOW_START_LIMIT = 1'b1
    } reg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;  // latch the accepted transfer
        logic step;     // first update step of an item
        logic loop;     // one avoidance growth iteration
        logic emit;     // load the result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ack_zero;
        logic avoid_mode;
        logic loop_more;
        logic out_free;
    } dp_sts_t;

endpackage

// File: rtl/twgc_datapath.sv
// ---------------------------------------------------------------------------
// twgc_datapath
// Window state, input holding registers, growth arithmetic and the result
// register with its valid/stall handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module twgc_datapath #(
    parameter int unsigned INIT_SEGMENTS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  twgc_pkg::dp_cmd_t cmd,
    output twgc_pkg::dp_sts_t sts,
    input  logic              cfg_reinit,
    input  logic [15:0]       mss_new,
    input  logic [31:0]       limit_new,
    input  logic [15:0]       mss,
    input  logic [31:0]       limit,
    input  logic [31:0]       acked_bytes,
    input  logic [31:0]       in_flight_bytes,
    input  logic [15:0]       peer_window,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       window_bytes,
    output logic [31:0]       threshold_bytes,
    output logic              in_avoidance,
    output logic [15:0]       usable_window,
    output logic [15:0]       send_allowance
);
    import twgc_pkg::*;

    localparam logic [31:0] CWND_RESET = 32'(MSS_RESET * INIT_SEGMENTS);
    localparam logic        MODE_RESET = (CWND_RESET >= LIMIT_RESET);

    logic [31:0] acked_reg;
    logic [31:0] flight_reg;
    logic [15:0] peer_reg;
    logic [31:0] cwnd_reg,  cwnd_next;
    logic [32:0] accum_reg, accum_next;
    logic        mode_reg,  mode_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] win_out_reg;
    logic [31:0] thr_out_reg;
    logic        avoid_out_reg;
    logic [15:0] usable_out_reg;
    logic [15:0] allow_out_reg;

    logic [15:0] mss_eff;
    logic [15:0] mss_new_eff;
    logic [31:0] init_cwnd;
    logic [32:0] grow_sum;
    logic [31:0] ss_cwnd;
    logic [32:0] seg_sum;
    logic [31:0] seg_cwnd;
    logic        loop_more;
    logic [15:0] usable;
    logic [15:0] allow;

    function automatic logic in_flight_ok(input logic [31:0] f, input logic [15:0] u);
        return f < 32'(u);
    endfunction

    always_comb
    begin
        mss_eff     = (mss == 16'd0) ? 16'd1 : mss;
        mss_new_eff = (mss_new == 16'd0) ? 16'd1 : mss_new;
        init_cwnd   = 32'(32'(mss_new_eff) * 32'(INIT_SEGMENTS));

        grow_sum = {1'b0, cwnd_reg} + {1'b0, acked_reg};
        ss_cwnd  = grow_sum[32] ? '1 : grow_sum[31:0];
        seg_sum  = {1'b0, cwnd_reg} + 33'(mss_eff);
        seg_cwnd = seg_sum[32] ? '1 : seg_sum[31:0];

        loop_more = (accum_reg >= {1'b0, cwnd_reg});

        usable = (cwnd_reg < 32'(peer_reg)) ? cwnd_reg[15:0] : peer_reg;
        allow  = (in_flight_ok(flight_reg, usable)) ? (usable - flight_reg[15:0]) : 16'd0;
    end

    // window state update
    always_comb
    begin
        cwnd_next  = cwnd_reg;
        accum_next = accum_reg;
        mode_next  = mode_reg;
        if (cfg_reinit)
        begin
            cwnd_next  = init_cwnd;
            accum_next = '0;
            mode_next  = (init_cwnd >= limit_new);
        end
        else if (cmd.step && (acked_reg != 32'd0))
        begin
            if (!mode_reg)
            begin
                cwnd_next = ss_cwnd;
                if (ss_cwnd >= limit)
                begin
                    mode_next  = 1'b1;
                    accum_next = '0;
                end
            end
            else
            begin
                // accum < cwnd before the add, so 33 bits never wrap
                accum_next = accum_reg + {1'b0, acked_reg};
            end
        end
        else if (cmd.loop && loop_more)
        begin
            accum_next = accum_reg - {1'b0, cwnd_reg};
            cwnd_next  = seg_cwnd;
        end
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwnd_reg      <= CWND_RESET;
            accum_reg     <= '0;
            mode_reg      <= MODE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cwnd_reg      <= cwnd_next;
            accum_reg     <= accum_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            acked_reg  <= acked_bytes;
            flight_reg <= in_flight_bytes;
            peer_reg   <= peer_window;
        end
        if (cmd.emit)
        begin
            win_out_reg    <= cwnd_reg;
            thr_out_reg    <= limit;
            avoid_out_reg  <= mode_reg;
            usable_out_reg <= usable;
            allow_out_reg  <= allow;
        end
    end

    assign sts.ack_zero   = (acked_reg == 32'd0);
    assign sts.avoid_mode = mode_reg;
    assign sts.loop_more  = loop_more;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign window_bytes    = win_out_reg;
    assign threshold_bytes = thr_out_reg;
    assign in_avoidance    = avoid_out_reg;
    assign usable_window   = usable_out_reg;
    assign send_allowance  = allow_out_reg;

endmodule

// File: rtl/twgc_ctrl.sv
// ---------------------------------------------------------------------------
// twgc_ctrl
// Sequencer for one item: accept, update step, avoidance growth loop, emit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module twgc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  twgc_pkg::dp_sts_t sts,
    output twgc_pkg::dp_cmd_t cmd
);
    import twgc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_LOOP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   emit;

    // a new item may enter in the same cycle the previous result is emitted
    assign emit     = (state_reg == S_EMIT) && sts.out_free;
    assign in_stall = !((state_reg == S_IDLE) || emit);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.ack_zero || !sts.avoid_mode)
                    state_next = S_EMIT;
                else
                    state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (!sts.loop_more)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                    state_next = accept ? S_STEP : S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd.load_in = accept;
    assign cmd.step    = (state_reg == S_STEP);
    assign cmd.loop    = (state_reg == S_LOOP);
    assign cmd.emit    = emit;

endmodule

// File: rtl/tcp_window_growth_controller.sv
// ---------------------------------------------------------------------------
// tcp_window_growth_controller
// Sequence: accept latches the ack, the step state updates the window or the
//   accumulator, in avoidance the loop state adds one segment per cycle, then
//   emit loads the result register once the result channel is free. A new ack
//   is taken only while idle or in the emit cycle, so items never overlap.
// Reset: window = MSS * INIT_SEGMENTS, accumulator cleared, no result pending.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcp_window_growth_controller #(
    parameter int unsigned INIT_SEGMENTS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twgc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // ack input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [31:0]                  acked_bytes,
    input  logic [31:0]                  in_flight_bytes,
    input  logic [15:0]                  peer_window,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [31:0]                  window_bytes,
    output logic [31:0]                  threshold_bytes,
    output logic                         in_avoidance,
    output logic [15:0]                  usable_window,
    output logic [15:0]                  send_allowance
);
    import twgc_pkg::*;

    // Config registers. Any write reinitializes the window state from the
    // values that become current at the same edge, exactly as reset does.
    logic [15:0] mss_reg,   mss_next;
    logic [31:0] limit_reg, limit_next;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);   // word-addressed, low bits ignored

    always_comb
    begin
        mss_next   = mss_reg;
        limit_next = limit_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SEGMENT_SIZE:     mss_next   = pwdata[15:0];
                REG_SLOW_START_LIMIT: limit_next = pwdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SEGMENT_SIZE:     prdata = {16'd0, mss_reg};
            REG_SLOW_START_LIMIT: prdata = limit_reg;
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_reg   <= MSS_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            mss_reg   <= mss_next;
            limit_reg <= limit_next;
        end
    end

    // Sequencer: idle -> step -> (avoidance loop) -> emit. The emit cycle
    // doubles as the accept cycle of the next transfer.
    twgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Window state, growth arithmetic and result register.
    twgc_datapath #(
        .INIT_SEGMENTS (INIT_SEGMENTS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_reinit      (cfg_wr),
        .mss_new         (mss_next),
        .limit_new       (limit_next),
        .mss             (mss_reg),
        .limit           (limit_reg),
        .acked_bytes     (acked_bytes),
        .in_flight_bytes (in_flight_bytes),
        .peer_window     (peer_window),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .window_bytes    (window_bytes),
        .threshold_bytes (threshold_bytes),
        .in_avoidance    (in_avoidance),
        .usable_window   (usable_window),
        .send_allowance  (send_allowance)
    );

    // one item at a time: an accepted transfer always blocks the next cycle
    `ASSERT_NEXT(a_no_back_to_back, in_valid && !in_stall, in_stall, "back-to-back accept")
    // window never reaches zero (MSS of zero counts as one)
    `ASSERT_NOW(a_window_nonzero, out_valid, window_bytes != 32'd0, "zero window reported")
    // avoidance only once the window has reached the threshold
    `ASSERT_NOW(a_avoid_above_thr, out_valid && in_avoidance, window_bytes >= threshold_bytes, "avoidance below threshold")
    // allowance never exceeds the usable window
    `ASSERT_NOW(a_allow_le_usable, out_valid, send_allowance <= usable_window, "allowance above usable window")

endmodule

// File: dv/tcp_window_growth_controller_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcp_window_growth_controller_tb
// Self-checking bench for the TCP window growth controller. A cycle-free
// predictor tracks window, avoidance accumulator and mode, and computes each
// report as an ack transfer is accepted. A monitor compares every result
// transfer, field by field, with the oldest pending report. Directed tests
// cover reset state, the threshold crossing, a zero segment size and
// saturation. Random traffic follows under three sender/receiver idle
// profiles, with the registers rewritten between bursts.
// ---------------------------------------------------------------------------

module tcp_window_growth_controller_tb;

    import twgc_pkg::*;

    localparam int unsigned INIT_SEGS     = 10;
    localparam int          STEP_CAP      = 400;    // max growth steps per random ack
    localparam int          LATENCY_SLACK = 8;      // idle cycles before a register write
    localparam int          DRAIN_LIMIT   = 100000; // cycles to wait for pending reports
    localparam int          BURST_ITEMS   = 120;    // random acks between reconfigurations

    // one result transfer as the block reports it
    typedef struct packed {
        logic [31:0] window;
        logic [31:0] threshold;
        logic        avoid;
        logic [15:0] usable;
        logic [15:0] allowance;
    } window_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // configuration port
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // ack channel
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] acked_bytes = '0;
    logic [31:0] in_flight_bytes = '0;
    logic [15:0] peer_window = '0;

    // report channel
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] window_bytes;
    logic [31:0] threshold_bytes;
    logic        in_avoidance;
    logic [15:0] usable_window;
    logic [15:0] send_allowance;

    // predictor copy of registers and state
    logic [15:0] seg_size;
    logic [31:0] slow_limit;
    logic [31:0] cwnd;
    logic [63:0] accum;
    logic        avoiding;

    window_report_t expected_reports[$];
    window_report_t oldest_report;
    int             error_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;

    tcp_window_growth_controller #(
        .INIT_SEGMENTS(INIT_SEGS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .acked_bytes     (acked_bytes),
        .in_flight_bytes (in_flight_bytes),
        .peer_window     (peer_window),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .window_bytes    (window_bytes),
        .threshold_bytes (threshold_bytes),
        .in_avoidance    (in_avoidance),
        .usable_window   (usable_window),
        .send_allowance  (send_allowance)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // a zero MSS behaves as one byte
    function automatic logic [31:0] effective_mss();
        return (seg_size == 16'd0) ? 32'd1 : {16'd0, seg_size};
    endfunction

    function automatic logic [31:0] sat_add(logic [31:0] base, logic [63:0] amount);
        logic [63:0] sum;
        sum = {32'd0, base} + amount;
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // reset and every register write bring the window back to its initial size
    function automatic void restart_window();
        logic [63:0] init_bytes;
        init_bytes = {32'd0, effective_mss()} * INIT_SEGS;
        cwnd = (init_bytes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : init_bytes[31:0];
        accum = '0;
        avoiding = (cwnd >= slow_limit);
    endfunction

    // number of one-segment growth steps an ack would trigger (capped),
    // used to keep random acks from stalling the block for too long
    function automatic int growth_steps(logic [31:0] acked);
        int          steps;
        logic [63:0] acc;
        logic [31:0] win;
        steps = 0;
        if (!avoiding || acked == 32'd0)
            return 0;
        acc = accum + {32'd0, acked};
        win = cwnd;
        while (acc >= {32'd0, win} && steps <= STEP_CAP)
        begin
            acc = acc - {32'd0, win};
            win = sat_add(win, {32'd0, effective_mss()});
            steps++;
        end
        return steps;
    endfunction

    function automatic window_report_t apply_ack(logic [31:0] acked, logic [31:0] flight,
                                                 logic [15:0] peer);
        window_report_t rep;
        logic [31:0]    usable;
        if (acked != 32'd0)
        begin
            if (!avoiding)
            begin
                // slow start: byte counting growth
                cwnd = sat_add(cwnd, {32'd0, acked});
                if (cwnd >= slow_limit)
                begin
                    avoiding = 1'b1;
                    accum = '0;
                end
            end
            else
            begin
                // avoidance: one segment per full window of acked bytes
                accum = accum + {32'd0, acked};
                while (cwnd != 32'd0 && accum >= {32'd0, cwnd})
                begin
                    accum = accum - {32'd0, cwnd};
                    cwnd = sat_add(cwnd, {32'd0, effective_mss()});
                end
                accum = accum & 64'h1_FFFF_FFFF;
            end
        end
        usable = (cwnd < {16'd0, peer}) ? cwnd : {16'd0, peer};
        rep.window = cwnd;
        rep.threshold = slow_limit;
        rep.avoid = avoiding;
        rep.usable = usable[15:0];
        rep.allowance = (flight >= usable) ? 16'd0 : 16'(usable - flight);
        return rep;
    endfunction

    // -----------------------------------------------------------------------
    // Report monitor and receiver stall
    // -----------------------------------------------------------------------

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report transfer, expected none, actual window %0h",
                         $time, window_bytes);
                error_count++;
            end
            else
            begin
                oldest_report = expected_reports.pop_front();
                check_field("window_bytes", oldest_report.window, window_bytes);
                check_field("threshold_bytes", oldest_report.threshold, threshold_bytes);
                check_field("in_avoidance", {31'd0, oldest_report.avoid},
                            {31'd0, in_avoidance});
                check_field("usable_window", {16'd0, oldest_report.usable},
                            {16'd0, usable_window});
                check_field("send_allowance", {16'd0, oldest_report.allowance},
                            {16'd0, send_allowance});
            end
        end
        out_stall <= rst_n ? ($urandom_range(99) < recv_idle_pct) : 1'b0;
    end

    // -----------------------------------------------------------------------
    // Shared driver tasks
    // -----------------------------------------------------------------------

    // Called right after clk rises. Optionally idles, then presents one ack
    // and holds it until the transfer completes; the report is predicted there.
    task automatic send_ack(logic [31:0] acked, logic [31:0] flight, logic [15:0] peer);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        acked_bytes <= acked;
        in_flight_bytes <= flight;
        peer_window <= peer;
        do
            @(posedge clk);
        while (in_stall);
        expected_reports.push_back(apply_ack(acked, flight, peer));
    endtask

    // Stop sending and let every pending report drain, then wait out the
    // LATENCY_SLACK margin, so the block is idle.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    // APB write followed by a read back of the same register
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        logic [31:0] readback;
        case (idx)
            REG_SEGMENT_SIZE:     seg_size = value[15:0];
            REG_SLOW_START_LIMIT: slow_limit = value;
            default:              ;
        endcase
        restart_window();
        readback = (idx == REG_SEGMENT_SIZE) ? {16'd0, seg_size} : slow_limit;

        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // read setup
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== readback)
        begin
            $display("%0t: register %s read back mismatch, expected %0h, actual %0h",
                     $time, idx.name(), readback, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset values: MSS 1460, threshold all ones, so slow start.
    task automatic test_reset_state();
        send_ack(32'd0, 32'd0, 16'd0);                 // zero ack, zero peer window
        send_ack(32'd0, 32'hFFFF_FFFF, 16'hFFFF);      // flight beyond everything
        send_ack(32'd1, 32'd0, 16'hFFFF);              // window limits usable
        send_ack(32'd1000, 32'd14000, 16'd16000);
        settle();
    endtask

    // Slow start reaches the threshold, then avoidance adds one segment per
    // full window of acked bytes.
    task automatic test_threshold_crossing();
        write_register(REG_SEGMENT_SIZE, 32'd1000);
        write_register(REG_SLOW_START_LIMIT, 32'd12000);
        send_ack(32'd1999, 32'd500, 16'd20000);        // one byte short
        send_ack(32'd1, 32'd11000, 16'd20000);         // lands on threshold
        send_ack(32'd11999, 32'd0, 16'd11000);         // accumulator one short
        send_ack(32'd1, 32'd12999, 16'd65535);         // exactly one window
        send_ack(32'd26000, 32'd1, 16'd65535);         // leftover just below window
        send_ack(32'd0, 32'd0, 16'd65535);             // zero ack in avoidance
        settle();
    endtask

    // MSS zero counts as one byte; threshold zero starts in avoidance.
    task automatic test_zero_segment();
        write_register(REG_SEGMENT_SIZE, 32'd0);
        write_register(REG_SLOW_START_LIMIT, 32'd0);
        send_ack(32'd10, 32'd0, 16'hFFFF);
        send_ack(32'd25, 32'd5, 16'd20);               // two growth steps
        send_ack(32'd3, 32'd100, 16'hFFFF);
        settle();
    endtask

    // Window saturates at all ones and stays there through avoidance.
    task automatic test_saturation();
        write_register(REG_SEGMENT_SIZE, 32'hFFFF);
        write_register(REG_SLOW_START_LIMIT, 32'hFFFF_FFFF);
        send_ack(32'hFFFF_FFFF, 32'd0, 16'hFFFF);
        send_ack(32'hFFFF_FFFF, 32'hAAAA_AAAA, 16'h5555);
        send_ack(32'hFFFF_FFFE, 32'h5555_5555, 16'hAAAA);
        send_ack(32'd2, 32'd65534, 16'hFFFF);
        settle();
    endtask

    // Random acks under one idle profile; the registers are rewritten with a
    // mix of extreme and random values every burst.
    task automatic test_random_traffic(int send_pct, int recv_pct, int items);
        logic [31:0] acked;
        logic [31:0] flight;
        logic [15:0] peer;
        logic [31:0] twice_window;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < items; n++)
        begin
            if (n % BURST_ITEMS == 0)
            begin
                settle();
                case ($urandom_range(4))
                    0:       write_register(REG_SEGMENT_SIZE, 32'd0);
                    1:       write_register(REG_SEGMENT_SIZE, 32'hFFFF);
                    2:       write_register(REG_SEGMENT_SIZE, 32'd536);
                    default: write_register(REG_SEGMENT_SIZE, {16'd0, 16'($urandom())});
                endcase
                case ($urandom_range(5))
                    0:       write_register(REG_SLOW_START_LIMIT, 32'd0);
                    1:       write_register(REG_SLOW_START_LIMIT, 32'hFFFF_FFFF);
                    2:       write_register(REG_SLOW_START_LIMIT, $urandom());
                    3:       write_register(REG_SLOW_START_LIMIT, 32'd1);
                    default: write_register(REG_SLOW_START_LIMIT, $urandom_range(2621400, 1));
                endcase
            end

            twice_window = (cwnd > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : {cwnd[30:0], 1'b0};
            case ($urandom_range(9))
                0:          acked = 32'd0;
                1, 2, 3, 4: acked = $urandom_range(3000, 1);
                5, 6:       acked = $urandom_range(twice_window, 1);
                7:          acked = $urandom_range(32'h0010_0000, 1);
                default:    acked = $urandom();
            endcase
            // keep avoidance growth loops short
            while (growth_steps(acked) > STEP_CAP)
                acked = acked >> 1;

            case ($urandom_range(7))
                0:       flight = 32'd0;
                1:       flight = $urandom();
                2:       flight = 32'hFFFF_FFFF;
                3, 4:    flight = $urandom_range(70000);
                default: flight = $urandom_range(65535);
            endcase
            case ($urandom_range(7))
                0:       peer = 16'd0;
                1:       peer = 16'hFFFF;
                default: peer = 16'($urandom_range(65535));
            endcase
            send_ack(acked, flight, peer);
        end
        settle();
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        seg_size = MSS_RESET;
        slow_limit = LIMIT_RESET;
        restart_window();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs under the first idle profile
        send_idle_pct = 37;
        recv_idle_pct = 87;
        test_reset_state();
        test_threshold_crossing();
        test_zero_segment();
        test_saturation();

        test_random_traffic(37, 87, 370);
        test_random_traffic(87, 37, 370);
        test_random_traffic(0, 0, 370);

        if (expected_reports.size() != 0)
        begin
            $display("%0t: %0d reports expected but never transferred",
                     $time, expected_reports.size());
            error_count++;
        end

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog: well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
